@@ design/ptts_pkg.sv @@
// ptts_pkg: shared types and constants of the periodic task tick scheduler
// used by ptts_cell, periodic_task_tick_scheduler_core and ptts_checker
// no dependencies
package ptts_pkg;

   localparam int NUM_SLOTS     = 8;
   localparam int MAX_RUNS_OUT  = 8;
   localparam int RUN_CNT_W     = $clog2(MAX_RUNS_OUT + 1);
   localparam int SLOT_W        = 3;
   localparam int TAG_W         = 8;
   localparam int TIME_W        = 16;

   localparam logic [7:0]        RUN_SAT       = 8'hff;
   localparam logic [TIME_W-1:0] TICK_STEP_RST = 16'd1;

   typedef logic [1:0] op_type;
   localparam op_type OP_ADD      = 2'd0;
   localparam op_type OP_DEL      = 2'd1;
   localparam op_type OP_TICK     = 2'd2;
   localparam op_type OP_DISPATCH = 2'd3;

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_ADD  = 2'd0;
   localparam kind_type KIND_DEL  = 2'd1;
   localparam kind_type KIND_RUN  = 2'd2;
   localparam kind_type KIND_NONE = 2'd3;

   // request broadcast to every cell while it walks
   typedef struct packed {
      op_type            op;
      logic [SLOT_W-1:0] slot;
      logic [TAG_W-1:0]  tag;
      logic [TIME_W-1:0] period;
      logic [TIME_W-1:0] delay;
      logic [TIME_W-1:0] step;
   } cmd_type;

   // token handed from cell to cell
   typedef struct packed {
      logic                 valid;
      logic                 found;
      logic                 was;
      logic [RUN_CNT_W-1:0] runs_out;
   } tok_type;

   // what the cell holding the token reports
   typedef struct packed {
      logic             place;
      logic             run;
      logic [TAG_W-1:0] tag;
   } evt_type;

endpackage

@@ design/ptts_cell.sv @@
// ptts_cell: one task slot of the scheduler chain, acts when the token is here
// depends on ptts_pkg
module ptts_cell #(
   parameter int Idx = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  ptts_pkg::cmd_type cmd,
   input  logic              shift,
   input  ptts_pkg::tok_type tok_prev,
   output ptts_pkg::tok_type tok_out,
   output ptts_pkg::evt_type evt
);
   import ptts_pkg::*;

   tok_type           tok_ff;
   logic              used_ff, used_in;
   logic [TAG_W-1:0]  tag_ff, tag_in;
   logic [TIME_W-1:0] period_ff, period_in;
   logic [TIME_W-1:0] delay_ff, delay_in;
   logic [7:0]        runs_ff, runs_in;
   tok_type           tok_nx;
   logic [TIME_W-1:0] delay_dec;
   logic              delay_le;

   assign delay_dec = delay_ff - cmd.step;
   assign delay_le  = (delay_ff <= cmd.step);

   always_comb begin
      used_in   = used_ff;
      tag_in    = tag_ff;
      period_in = period_ff;
      delay_in  = delay_ff;
      runs_in   = runs_ff;
      tok_nx    = tok_ff;
      evt       = '0;
      if (tok_ff.valid) begin
         unique case (cmd.op)
            OP_ADD: begin
               if (!tok_ff.found && !used_ff) begin
                  used_in      = 1'b1;
                  tag_in       = cmd.tag;
                  period_in    = cmd.period;
                  delay_in     = cmd.delay;
                  runs_in      = '0;
                  tok_nx.found = 1'b1;
                  evt.place    = 1'b1;
               end
            end
            OP_DEL: begin
               if (used_ff && (32'(cmd.slot) == 32'(Idx))) begin
                  used_in    = 1'b0;
                  period_in  = '0;
                  delay_in   = '0;
                  runs_in    = '0;
                  tok_nx.was = 1'b1;
               end
            end
            OP_TICK: begin
               if (used_ff) begin
                  if (delay_ff == '0) begin
                     if (runs_ff != RUN_SAT) runs_in = runs_ff + 8'd1;
                     if (period_ff != '0) delay_in = period_ff - 16'd1;
                  end else if (delay_le) begin
                     delay_in = '0;
                  end else begin
                     delay_in = delay_dec;
                  end
               end
            end
            OP_DISPATCH: begin
               if (used_ff && (runs_ff != '0) &&
                   (tok_ff.runs_out < RUN_CNT_W'(MAX_RUNS_OUT))) begin
                  evt.run         = 1'b1;
                  evt.tag         = tag_ff;
                  runs_in         = runs_ff - 8'd1;
                  tok_nx.runs_out = tok_ff.runs_out + RUN_CNT_W'(1);
                  // one-shot task leaves after its run goes out
                  if (period_ff == '0) begin
                     used_in   = 1'b0;
                     delay_in  = '0;
                     runs_in   = '0;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   assign tok_out = tok_nx;

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff    <= '0;
         used_ff   <= 1'b0;
         period_ff <= '0;
         delay_ff  <= '0;
         runs_ff   <= '0;
      end else if (shift) begin
         tok_ff    <= tok_prev;
         used_ff   <= used_in;
         period_ff <= period_in;
         delay_ff  <= delay_in;
         runs_ff   <= runs_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         tag_ff <= tag_in;
      end
   end

endmodule

@@ design/periodic_task_tick_scheduler_core.sv @@
// periodic_task_tick_scheduler_core: top level of the task tick scheduler
// depends on ptts_pkg and ptts_cell
//
//   channel   ports    direction  moves
//   request   req_*    in         add, delete, tick or dispatch request
//   response  rsp_*    out        add/delete answer, run task, nothing pending
//   csr       csr_*    in         tick_step write
//
// a request is accepted, then a token walks the chain of cells slot by slot,
// then the answer is handed out (a tick request gives no answer)
// a dispatch walk pauses only while a run result finds both the hold stage
// and the response register full under rsp_stall
// reset clears every slot and sets tick_step to 1; no clearing pass
module periodic_task_tick_scheduler_core #(
   parameter int SLOTS = ptts_pkg::NUM_SLOTS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  ptts_pkg::op_type             req_operation,
   input  logic [ptts_pkg::SLOT_W-1:0]  req_slot,
   input  logic [ptts_pkg::TAG_W-1:0]   req_task_tag,
   input  logic [ptts_pkg::TIME_W-1:0]  req_period,
   input  logic [ptts_pkg::TIME_W-1:0]  req_delay,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output ptts_pkg::kind_type           rsp_result_kind,
   output logic [ptts_pkg::SLOT_W-1:0]  rsp_slot_res,
   output logic [ptts_pkg::TAG_W-1:0]   rsp_task_tag_res,
   output logic                         rsp_ok,
   output logic                         rsp_last,
   input  logic                         csr_wr_en,
   input  logic [ptts_pkg::TIME_W-1:0]  csr_wr_data
);
   import ptts_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(SLOTS - 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WALK = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic [TIME_W-1:0] tick_step_ff;

   // latched request
   op_type            op_ff, op_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [TAG_W-1:0]  tag_ff, tag_in;
   logic [TIME_W-1:0] period_ff, period_in;
   logic [TIME_W-1:0] delay_ff, delay_in;

   // token after the last cell, and the slot an add filled
   tok_type           fin_ff, fin_in;
   logic [IDX_W-1:0]  found_idx_ff, found_idx_in;

   // run result waiting until we know whether it is the last
   logic              hold_v_ff, hold_v_in;
   logic [IDX_W-1:0]  hold_slot_ff, hold_slot_in;
   logic [TAG_W-1:0]  hold_tag_ff, hold_tag_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   kind_type          rsp_kind_ff, rsp_kind_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [TAG_W-1:0]  rsp_tag_ff, rsp_tag_in;
   logic              rsp_ok_ff, rsp_ok_in;
   logic              rsp_last_ff, rsp_last_in;

   cmd_type           cmd_bus;
   tok_type           tok_link [SLOTS+1];
   evt_type           evt_cell [SLOTS];
   evt_type           evt_any;
   logic              accept, out_free, emit_ok, adv, shift;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit_ok   = !hold_v_ff || out_free;
   // the walk waits only when a run result has nowhere to go
   assign adv       = !evt_any.run || emit_ok;
   assign shift     = accept || ((state_ff == ST_WALK) && adv);

   always_comb begin
      cmd_bus.op     = op_ff;
      cmd_bus.slot   = slot_ff;
      cmd_bus.tag    = tag_ff;
      cmd_bus.period = period_ff;
      cmd_bus.delay  = delay_ff;
      cmd_bus.step   = tick_step_ff;
   end

   // fresh token enters cell 0 only with an accepted request
   assign tok_link[0] = '{valid: accept, found: 1'b0, was: 1'b0, runs_out: '0};

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      ptts_cell #(
         .Idx (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd_bus),
         .shift    (shift),
         .tok_prev (tok_link[i]),
         .tok_out  (tok_link[i+1]),
         .evt      (evt_cell[i])
      );
   end

   // only the cell holding the token reports, so an or gathers it
   always_comb begin
      evt_any = '0;
      for (int i = 0; i < SLOTS; i++) begin
         evt_any = evt_any | evt_cell[i];
      end
   end

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      op_in        = op_ff;
      slot_in      = slot_ff;
      tag_in       = tag_ff;
      period_in    = period_ff;
      delay_in     = delay_ff;
      fin_in       = fin_ff;
      found_idx_in = found_idx_ff;
      hold_v_in    = hold_v_ff;
      hold_slot_in = hold_slot_ff;
      hold_tag_in  = hold_tag_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in  = rsp_kind_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in  = ST_WALK;
               pos_in    = '0;
               op_in     = req_operation;
               slot_in   = req_slot;
               tag_in    = req_task_tag;
               period_in = req_period;
               delay_in  = req_delay;
               hold_v_in = 1'b0;
            end
         end
         ST_WALK: begin
            if (adv) begin
               if (evt_any.place) found_idx_in = pos_ff;
               if (evt_any.run) begin
                  // a newer run exists, so the held one is not the last
                  if (hold_v_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_RUN;
                     rsp_slot_in  = SLOT_W'(hold_slot_ff);
                     rsp_tag_in   = hold_tag_ff;
                     rsp_ok_in    = 1'b0;
                     rsp_last_in  = 1'b0;
                  end
                  hold_v_in    = 1'b1;
                  hold_slot_in = pos_ff;
                  hold_tag_in  = evt_any.tag;
               end
               if (pos_ff == LAST_POS) begin
                  state_in = ST_DONE;
                  fin_in   = tok_link[SLOTS];
               end else begin
                  pos_in = pos_ff + IDX_W'(1);
               end
            end
         end
         ST_DONE: begin
            if (op_ff == OP_TICK) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_tag_in   = '0;
               rsp_ok_in    = 1'b0;
               rsp_last_in  = 1'b1;
               hold_v_in    = 1'b0;
               unique case (op_ff)
                  OP_ADD: begin
                     rsp_kind_in = KIND_ADD;
                     rsp_slot_in = fin_ff.found ? SLOT_W'(found_idx_ff) : '0;
                     rsp_ok_in   = fin_ff.found;
                  end
                  OP_DEL: begin
                     // out-of-range slot simply finds no cell
                     rsp_kind_in = KIND_DEL;
                     rsp_slot_in = slot_ff;
                     rsp_ok_in   = fin_ff.was;
                  end
                  default: begin
                     if (hold_v_ff) begin
                        rsp_kind_in = KIND_RUN;
                        rsp_slot_in = SLOT_W'(hold_slot_ff);
                        rsp_tag_in  = hold_tag_ff;
                     end else begin
                        rsp_kind_in = KIND_NONE;
                        rsp_slot_in = '0;
                     end
                  end
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_step_ff <= TICK_STEP_RST;
         hold_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hold_v_ff    <= hold_v_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) tick_step_ff <= csr_wr_data;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      op_ff        <= op_in;
      slot_ff      <= slot_in;
      tag_ff       <= tag_in;
      period_ff    <= period_in;
      delay_ff     <= delay_in;
      fin_ff       <= fin_in;
      found_idx_ff <= found_idx_in;
      hold_slot_ff <= hold_slot_in;
      hold_tag_ff  <= hold_tag_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = rsp_kind_ff;
   assign rsp_slot_res     = rsp_slot_ff;
   assign rsp_task_tag_res = rsp_tag_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

@@ design/ptts_checker.sv @@
// ptts_checker: port-level assertions for the task tick scheduler, with bind
// depends on ptts_pkg and periodic_task_tick_scheduler_core
module ptts_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input ptts_pkg::kind_type           rsp_result_kind,
   input logic [ptts_pkg::SLOT_W-1:0]  rsp_slot_res,
   input logic [ptts_pkg::TAG_W-1:0]   rsp_task_tag_res,
   input logic                         rsp_ok,
   input logic                         rsp_last
);
   import ptts_pkg::*;

   // reset empties the response register
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // one request at a time: an accepted request closes the request side
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while another is in work");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_result_kind) &&
         $stable(rsp_slot_res) && $stable(rsp_task_tag_res) &&
         $stable(rsp_ok) && $stable(rsp_last)))
      else $error("stalled response changed");

   // only run results may be followed by more of the same request
   a_single_answers_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_result_kind != KIND_RUN)) |-> rsp_last)
      else $error("single answer without last");

   // ok only on add and delete answers
   a_ok_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ok) |-> ((rsp_result_kind == KIND_ADD) ||
                                 (rsp_result_kind == KIND_DEL)))
      else $error("ok set on a run or nothing-pending result");

endmodule

bind periodic_task_tick_scheduler_core ptts_checker u_ptts_checker (.*);
